/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* src/ils_pkg.sv */
// Types and constants of the indexed list store.
`timescale 1ns / 1ps
package ils_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int OP_W   = 3;
   localparam int POS_W  = 7;
   localparam int WORD_W = 32;
   localparam int STAT_W = 2;
   localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 3'd0,
      OP_INSERT = 3'd1,
      OP_READ   = 3'd2,
      OP_WRITE  = 3'd3,
      OP_REMOVE = 3'd4,
      OP_CLEAR  = 3'd5
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_W-1:0]     wr_addr;
      logic [DATA_WIDTH-1:0] wr_data;
      logic                  rd_en;
      logic [ADDR_W-1:0]     rd_addr;
   } ram_req_type;

endpackage

/* src/indexed_list_store.sv */
// Indexed list store: ordered word list with insert and remove at a position.
// Append, clear, errors and unknown ops answer from the execute state; read, write and remove pass through a read wait.
// Insert moves the tail up, last entry first, then writes the word at the position (at the tail it writes at once);
// remove pulls the tail down after the read: the memory writes one entry per cycle while it reads the next.
// One item at a time; busy is high from acceptance until the result strobe.
// Synchronous reset empties the list; entry contents are not cleared.
`timescale 1ns / 1ps
module indexed_list_store
   import ils_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [OP_W-1:0]   req_op,
   input  logic [POS_W-1:0]  req_position,
   input  logic [WORD_W-1:0] req_item_word,
   output logic              rsp_valid,
   output logic [WORD_W-1:0] rsp_data_out,
   output logic [STAT_W-1:0] rsp_status,
   output logic [POS_W-1:0]  rsp_count
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RD_WAIT,
      S_SHIFT_UP,
      S_FINAL_WR,
      S_SHIFT_DN
   } state_type;

   state_type             state_ff, state_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic [ADDR_W-1:0]     cur_ff, cur_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]      rsp_count_ff, rsp_count_in;

   ram_req_type           ram_req;
   logic [DATA_WIDTH-1:0] rd_data;

   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic [CMP_W-1:0] cur_ext;
   logic             full;
   logic [CNT_W-1:0] count_inc;
   logic [CNT_W-1:0] count_dec;

   ils_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   assign pos_ext   = CMP_W'(pos_ff);
   assign cnt_ext   = CMP_W'(count_ff);
   assign cur_ext   = CMP_W'(cur_ff);
   assign full      = (cnt_ext >= CMP_W'(CAPACITY));
   assign count_inc = CNT_W'(count_ff + 1'b1);
   assign count_dec = CNT_W'(count_ff - 1'b1);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      word_in       = word_ff;
      data_in       = data_ff;
      cur_in        = cur_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      ram_req       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_op;
               pos_in   = req_position;
               word_in  = DATA_WIDTH'(req_item_word);
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            // default: finish with a zero word, status ok, count unchanged
            rsp_valid_in  = 1'b1;
            rsp_data_in   = '0;
            rsp_status_in = ST_OK;
            rsp_count_in  = POS_W'(count_ff);
            state_in      = S_IDLE;
            unique case (op_type'(op_ff))
               OP_APPEND: begin
                  if (full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     ram_req.wr_en   = 1'b1;
                     ram_req.wr_addr = ADDR_W'(count_ff);
                     ram_req.wr_data = word_ff;
                     count_in        = count_inc;
                     rsp_count_in    = POS_W'(count_inc);
                  end
               end
               OP_INSERT: begin
                  if (pos_ext > cnt_ext) begin
                     rsp_status_in = ST_RANGE;
                  end else if (full) begin
                     rsp_status_in = ST_FULL;
                  end else if (pos_ext == cnt_ext) begin
                     ram_req.wr_en   = 1'b1;
                     ram_req.wr_addr = ADDR_W'(count_ff);
                     ram_req.wr_data = word_ff;
                     count_in        = count_inc;
                     rsp_count_in    = POS_W'(count_inc);
                  end else begin
                     // start moving the tail up, last entry first
                     rsp_valid_in    = 1'b0;
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = ADDR_W'(count_dec);
                     cur_in          = ADDR_W'(count_dec);
                     state_in        = S_SHIFT_UP;
                  end
               end
               OP_READ, OP_WRITE, OP_REMOVE: begin
                  if (pos_ext >= cnt_ext) begin
                     rsp_status_in = ST_RANGE;
                  end else begin
                     rsp_valid_in    = 1'b0;
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = ADDR_W'(pos_ff);
                     state_in        = S_RD_WAIT;
                  end
               end
               OP_CLEAR: begin
                  count_in     = '0;
                  rsp_count_in = '0;
               end
               default: begin
               end
            endcase
         end

         S_RD_WAIT: begin
            rsp_data_in   = WORD_W'(rd_data);
            rsp_status_in = ST_OK;
            rsp_count_in  = POS_W'(count_ff);
            data_in       = rd_data;
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
            if (op_type'(op_ff) == OP_WRITE) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = ADDR_W'(pos_ff);
               ram_req.wr_data = word_ff;
            end else if (op_type'(op_ff) == OP_REMOVE) begin
               if ((pos_ext + 1'b1) < cnt_ext) begin
                  // pull the tail down one entry at a time
                  rsp_valid_in    = 1'b0;
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = ADDR_W'(pos_ext + 1'b1);
                  cur_in          = ADDR_W'(pos_ext + 1'b1);
                  state_in        = S_SHIFT_DN;
               end else begin
                  count_in     = count_dec;
                  rsp_count_in = POS_W'(count_dec);
               end
            end
         end

         S_SHIFT_UP: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = ADDR_W'(cur_ext + 1'b1);
            ram_req.wr_data = rd_data;
            if (cur_ext == pos_ext) begin
               state_in = S_FINAL_WR;
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = ADDR_W'(cur_ff - 1'b1);
               cur_in          = ADDR_W'(cur_ff - 1'b1);
            end
         end

         S_FINAL_WR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = ADDR_W'(pos_ff);
            ram_req.wr_data = word_ff;
            count_in        = count_inc;
            rsp_valid_in    = 1'b1;
            rsp_data_in     = '0;
            rsp_status_in   = ST_OK;
            rsp_count_in    = POS_W'(count_inc);
            state_in        = S_IDLE;
         end

         S_SHIFT_DN: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = ADDR_W'(cur_ff - 1'b1);
            ram_req.wr_data = rd_data;
            if ((cur_ext + 1'b1) < cnt_ext) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = ADDR_W'(cur_ext + 1'b1);
               cur_in          = ADDR_W'(cur_ext + 1'b1);
            end else begin
               count_in      = count_dec;
               rsp_valid_in  = 1'b1;
               rsp_data_in   = WORD_W'(data_ff);
               rsp_status_in = ST_OK;
               rsp_count_in  = POS_W'(count_dec);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      word_ff       <= word_in;
      data_ff       <= data_in;
      cur_ff        <= cur_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

/* src/ils_ram.sv */
// Entry memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module ils_ram
   import ils_pkg::*;
(
   input  logic                  clock,
   input  ram_req_type           ram_req,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem_ff[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem_ff[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ils_checker.sv */
// Port-level checks for the indexed list store, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ils_checker
   import ils_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic [WORD_W-1:0] rsp_data_out,
   input logic [STAT_W-1:0] rsp_status,
   input logic [POS_W-1:0]  rsp_count
);

   // an accepted transfer keeps the block busy in the next cycle
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // one result per item: a result strobe is never followed by another in the next cycle
   `ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `ASSERT_SAME(a_count_bound, clock, reset, rsp_valid,
                POS_W'(CAPACITY) >= rsp_count)
   `ASSERT_SAME(a_error_zero, clock, reset,
                rsp_valid && (rsp_status != ST_OK), rsp_data_out == '0)
   // full is only ever reported with the list at capacity
   `ASSERT_SAME(a_full_count, clock, reset,
                rsp_valid && (rsp_status == ST_FULL), rsp_count == POS_W'(CAPACITY))

endmodule

bind indexed_list_store ils_checker u_ils_checker (.*);

/* tb/indexed_list_store_tb.sv */
// Testbench for indexed_list_store: directed table, then random list traffic checked by a predictor.
`timescale 1ns / 1ps
module indexed_list_store_tb;
   import ils_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
   localparam logic [POS_W-1:0] FULL_COUNT = POS_W'(CAPACITY);
   localparam int RANDOM_ITEMS_PER_PHASE = 300;
   localparam int DIR_ROWS = 25;

   typedef struct packed {
      logic [WORD_W-1:0] data;
      status_type        status;
      logic [POS_W-1:0]  count;
   } list_result_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [POS_W-1:0]  pos;
      logic [WORD_W-1:0] word;
      logic [7:0]        reps;
      logic              typed;
      list_result_type   res;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [OP_W-1:0]   req_op;
   logic [POS_W-1:0]  req_position;
   logic [WORD_W-1:0] req_item_word;
   logic              rsp_valid;
   logic [WORD_W-1:0] rsp_data_out;
   logic [STAT_W-1:0] rsp_status;
   logic [POS_W-1:0]  rsp_count;

   // Predictor copy of the list
   logic [DATA_WIDTH-1:0] list_words [CAPACITY];
   int                    list_len;

   list_result_type pending_results [$];
   int              failures;
   int              idle_pct;

   // Typed rows carry the result that can be read off directly; the rest use the predictor.
   stim_row_type dir_rows [DIR_ROWS] = '{
      '{OP_READ,   7'd0,   32'h0000_0000, 8'd1,  1'b1, '{32'h0, ST_RANGE, 7'd0}},
      '{OP_WRITE,  7'd0,   32'hFFFF_FFFF, 8'd1,  1'b1, '{32'h0, ST_RANGE, 7'd0}},
      '{OP_REMOVE, 7'd0,   32'h0000_0000, 8'd1,  1'b1, '{32'h0, ST_RANGE, 7'd0}},
      '{OP_INSERT, 7'd1,   32'hFFFF_FFFF, 8'd1,  1'b1, '{32'h0, ST_RANGE, 7'd0}},
      '{OP_INSERT, 7'd0,   32'hFFFF_FFFF, 8'd1,  1'b1, '{32'h0, ST_OK, 7'd1}},
      '{OP_APPEND, 7'd127, 32'h0000_0000, 8'd1,  1'b1, '{32'h0, ST_OK, 7'd2}},
      '{OP_INSERT, 7'd1,   32'hA5A5_A5A5, 8'd1,  1'b0, '{32'h0, ST_OK, 7'd0}},
      '{OP_READ,   7'd1,   32'h0000_0000, 8'd1,  1'b1, '{32'hA5A5_A5A5, ST_OK, 7'd3}},
      '{OP_WRITE,  7'd2,   32'h5A5A_5A5A, 8'd1,  1'b1, '{32'h0, ST_OK, 7'd3}},
      '{OP_REMOVE, 7'd0,   32'h0000_0000, 8'd1,  1'b1, '{32'hFFFF_FFFF, ST_OK, 7'd2}},
      '{OP_READ,   7'd127, 32'hFFFF_FFFF, 8'd1,  1'b1, '{32'h0, ST_RANGE, 7'd2}},
      '{OP_SPARE_A, 7'd0,  32'hFFFF_FFFF, 8'd1,  1'b1, '{32'h0, ST_OK, 7'd2}},
      '{OP_SPARE_B, 7'd127, 32'hFFFF_FFFF, 8'd1, 1'b1, '{32'h0, ST_OK, 7'd2}},
      '{OP_CLEAR,  7'd127, 32'hFFFF_FFFF, 8'd1,  1'b1, '{32'h0, ST_OK, 7'd0}},
      '{OP_APPEND, 7'd0,   32'hC3C3_0000, 8'd64, 1'b0, '{32'h0, ST_OK, 7'd0}},
      '{OP_APPEND, 7'd0,   32'hFFFF_FFFF, 8'd1,  1'b1, '{32'h0, ST_FULL, FULL_COUNT}},
      '{OP_INSERT, 7'd64,  32'h0000_0000, 8'd1,  1'b1, '{32'h0, ST_FULL, FULL_COUNT}},
      '{OP_INSERT, 7'd65,  32'h0000_0000, 8'd1,  1'b1, '{32'h0, ST_RANGE, FULL_COUNT}},
      '{OP_INSERT, 7'd0,   32'h0000_0000, 8'd1,  1'b1, '{32'h0, ST_FULL, FULL_COUNT}},
      '{OP_READ,   7'd64,  32'h0000_0000, 8'd1,  1'b1, '{32'h0, ST_RANGE, FULL_COUNT}},
      '{OP_READ,   7'd63,  32'h0000_0000, 8'd1,  1'b0, '{32'h0, ST_OK, 7'd0}},
      '{OP_REMOVE, 7'd0,   32'h0000_0000, 8'd1,  1'b0, '{32'h0, ST_OK, 7'd0}},
      '{OP_INSERT, 7'd0,   32'hFFFF_FFFF, 8'd1,  1'b0, '{32'h0, ST_OK, 7'd0}},
      '{OP_REMOVE, 7'd63,  32'h0000_0000, 8'd1,  1'b0, '{32'h0, ST_OK, 7'd0}},
      '{OP_CLEAR,  7'd0,   32'h0000_0000, 8'd1,  1'b1, '{32'h0, ST_OK, 7'd0}}
   };

   indexed_list_store dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_position  (req_position),
      .req_item_word (req_item_word),
      .rsp_valid     (rsp_valid),
      .rsp_data_out  (rsp_data_out),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("%0t: timeout", $realtime);
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic apply_list_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [WORD_W-1:0] word, output list_result_type res);
      int p;
      p = pos;
      res.data = '0;
      res.status = ST_OK;
      case (op)
         OP_APPEND: begin
            if (list_len >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               list_words[list_len] = word[DATA_WIDTH-1:0];
               list_len++;
            end
         end
         OP_INSERT: begin
            if (p > list_len) begin
               res.status = ST_RANGE;
            end else if (list_len >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               for (int i = list_len; i > p; i--) list_words[i] = list_words[i-1];
               list_words[p] = word[DATA_WIDTH-1:0];
               list_len++;
            end
         end
         OP_READ: begin
            if (p >= list_len) res.status = ST_RANGE;
            else res.data = WORD_W'(list_words[p]);
         end
         OP_WRITE: begin
            if (p >= list_len) begin
               res.status = ST_RANGE;
            end else begin
               res.data = WORD_W'(list_words[p]);
               list_words[p] = word[DATA_WIDTH-1:0];
            end
         end
         OP_REMOVE: begin
            if (p >= list_len) begin
               res.status = ST_RANGE;
            end else begin
               res.data = WORD_W'(list_words[p]);
               for (int i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
               list_len--;
            end
         end
         OP_CLEAR: list_len = 0;
         default: ;
      endcase
      res.count = POS_W'(list_len);
   endtask

   // Enter at a falling edge, leave at the falling edge after the transfer.
   task automatic issue_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [WORD_W-1:0] word, input logic typed,
                           input list_result_type typed_res);
      list_result_type res;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_position <= pos;
      req_item_word <= word;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      apply_list_op(op, pos, word, res);
      pending_results.push_back(typed ? typed_res : res);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      list_result_type exp;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected: data %h status %0d count %0d",
                     $realtime, rsp_data_out, rsp_status, rsp_count);
            failures++;
         end else begin
            exp = pending_results.pop_front();
            if (rsp_data_out !== exp.data) begin
               $display("%0t: data_out expected %h got %h", $realtime, exp.data, rsp_data_out);
               failures++;
            end
            if (rsp_status !== exp.status) begin
               $display("%0t: status expected %0d got %0d", $realtime, exp.status, rsp_status);
               failures++;
            end
            if (rsp_count !== exp.count) begin
               $display("%0t: count expected %0d got %0d", $realtime, exp.count, rsp_count);
               failures++;
            end
         end
      end
   end

   initial begin
      logic [OP_W-1:0]  op;
      logic [POS_W-1:0] pos;
      int               roll;
      int               run_left;
      int               guard;
      logic             growing;
      list_result_type  no_res;

      failures = 0;
      list_len = 0;
      idle_pct = 0;
      no_res = '0;
      growing = 1'b1;
      run_left = 0;
      reset = 1'b1;
      start = 1'b0;
      req_op = OP_APPEND;
      req_position = '0;
      req_item_word = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         for (int k = 0; k < dir_rows[r].reps; k++) begin
            issue_op(dir_rows[r].op, dir_rows[r].pos, dir_rows[r].word + WORD_W'(k),
                     dir_rows[r].typed, dir_rows[r].res);
         end
      end

      // Sender idle percentage per phase: none, heavy, light
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 1) ? 71 : ((ph == 2) ? 8 : 0);
         for (int n = 0; n < RANDOM_ITEMS_PER_PHASE; n++) begin
            // Alternate fill and drain runs so both the full and empty list are reached
            if (run_left == 0) begin
               growing = ~growing;
               run_left = $urandom_range(150, 40);
            end
            run_left--;
            roll = $urandom_range(99);
            if (roll < 2) op = OP_CLEAR;
            else if (roll < 4) op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
            else if (roll < 20) op = OP_READ;
            else if (roll < 32) op = OP_WRITE;
            else if ((roll < 82) == growing) op = $urandom_range(1) ? OP_APPEND : OP_INSERT;
            else op = OP_REMOVE;

            if (op == OP_INSERT && $urandom_range(99) < 85)
               pos = POS_W'($urandom_range(list_len));
            else if ((op == OP_READ || op == OP_WRITE || op == OP_REMOVE) && list_len > 0
                     && $urandom_range(99) < 85)
               pos = POS_W'($urandom_range(list_len - 1));
            else
               pos = POS_W'($urandom_range(127));

            issue_op(op, pos, $urandom, 1'b0, no_res);
         end
      end
      start <= 1'b0;

      guard = 0;
      while (pending_results.size() != 0 && guard < 1000) begin
         @(posedge clock);
         guard++;
      end
      if (pending_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $realtime, pending_results.size());
         failures++;
      end
      repeat (CAPACITY + 8) @(posedge clock);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
